[src/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg: shared types for the insertion sorter
// Holds the transfer payload structs, the cell control struct and the
// controller state type.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int unsigned DataW = 32;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [DataW-1:0] sorted_value;
        logic                    end_of_run;
        logic                    overflow;
    } out_item_t;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        logic                    load;
        logic                    shift;
        logic signed [DataW-1:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

[src/isort_cell.sv]
// ----------------------------------------------------------------------------
// isort_cell: one place of the sorted chain
// Holds one entry. On a load it keeps its entry, takes the new value or
// takes its left neighbor's entry; on a shift it takes its right neighbor's.
// ----------------------------------------------------------------------------
module isort_cell
    import isort_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic                    occ,
    input  logic                    left_occ,
    input  logic                    left_gt,
    input  logic signed [DataW-1:0] left_val,
    input  logic signed [DataW-1:0] right_val,
    output logic signed [DataW-1:0] val,
    output logic                    gt
);

    logic signed [DataW-1:0] val_reg;
    logic signed [DataW-1:0] val_next;

    // This entry is held and is strictly larger than the incoming value.
    assign gt  = occ && (val_reg > ctl.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.shift)
        begin
            val_next = right_val;
        end
        else if (ctl.load && (gt || !occ))
        begin
            if (left_gt)
            begin
                val_next = left_val;
            end
            else if (left_occ)
            begin
                val_next = ctl.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[src/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter: streaming insertion sorter for signed 32-bit values
// A chain of cells keeps the received values in ascending order and emits
// the whole set after the item flagged last.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer happens at a rising edge with start high and busy low.
// While loading, busy stays low, so one value can be taken every cycle: the
// new value is broadcast to all cells and each cell decides in one step
// whether to keep its entry, take the value or take its left neighbor's
// entry. Equal values keep their arrival order.
// After the item flagged last has been inserted, busy rises and the chain
// shifts toward cell 0 once per cycle. One result per held entry appears on
// result for exactly one cycle, marked by strobe; end_of_run marks the
// largest entry. The first result appears in the cycle after the last item's
// transfer. The receiver cannot stall, so results are presented back to back.
// Values arriving when DEPTH entries are already held are dropped, and every
// result of that run then carries overflow. After emission the count and
// the overflow flag clear and busy falls. Reset clears the count, the flag
// and the controller; cell contents are never read before being written.
// ----------------------------------------------------------------------------
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      strobe,
    output out_item_t result
);

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            dropped_reg;
    logic            dropped_next;

    logic            accept;
    logic            full;
    cell_ctl_t       ctl;

    logic signed [DataW-1:0] val_w [DEPTH];
    logic                    gt_w  [DEPTH];
    logic                    occ_w [DEPTH];

    assign accept = start && !busy;
    assign full   = (count_reg == CntW'(DEPTH));
    assign busy   = (state_reg == ST_EMIT);

    // The new value enters the chain only when there is room for it.
    assign ctl.load  = accept && !full;
    assign ctl.shift = (state_reg == ST_EMIT);
    assign ctl.value = item.value;

    // The chain is built from identical cells; cell 0 sees a held,
    // never-larger left neighbor so that it can take the smallest value.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            localparam int unsigned Idx = gi;
            logic                    l_occ;
            logic                    l_gt;
            logic signed [DataW-1:0] l_val;
            logic signed [DataW-1:0] r_val;

            assign occ_w[gi] = (CntW'(Idx) < count_reg);

            if (gi == 0)
            begin : g_first
                assign l_occ = 1'b1;
                assign l_gt  = 1'b0;
                assign l_val = val_w[gi];
            end
            else
            begin : g_mid
                assign l_occ = occ_w[gi-1];
                assign l_gt  = gt_w[gi-1];
                assign l_val = val_w[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign r_val = val_w[gi];
            end
            else
            begin : g_inner
                assign r_val = val_w[gi+1];
            end

            isort_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occ       (occ_w[gi]),
                .left_occ  (l_occ),
                .left_gt   (l_gt),
                .left_val  (l_val),
                .right_val (r_val),
                .val       (val_w[gi]),
                .gt        (gt_w[gi])
            );
        end
    endgenerate

    // Results always come from cell 0 while the chain drains.
    assign strobe              = busy;
    assign result.sorted_value = val_w[0];
    assign result.end_of_run   = (count_reg == CntW'(1));
    assign result.overflow     = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CntW'(1);
                    end
                    if (item.last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // During emission the count tracks the entries still to go.
                count_next = count_reg - CntW'(1);
                if (count_reg == CntW'(1))
                begin
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

`ifndef SYNTH
    // The held count never exceeds the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("held count exceeds DEPTH");

    // Emission never runs dry: a strobe always has an entry to go.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (count_reg != '0))
        else $error("emission with no held entry");

    // Results are back to back until the marked final one.
    a_emit_contig: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.end_of_run) |=> strobe)
        else $error("gap in emission before end of run");

    // After the final result the block is ready with a clean run.
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.end_of_run) |=> (!busy && count_reg == '0 && !dropped_reg))
        else $error("state not cleared after end of run");
`endif

endmodule
